@@ rtl/core/jsu_pkg.sv @@
// shared types, constants and helpers for the json string unescaper
`default_nettype none
package jsu_pkg;

    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_BAD_ESC = 3'd2;
    localparam logic [2:0] KIND_BAD_HEX = 3'd3;
    localparam logic [2:0] KIND_SURR    = 3'd4;
    localparam logic [2:0] KIND_UNTERM  = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // results caused by one input word, byte 0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0] kind;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_res;

    // {ok, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/jsu_decode.sv @@
// escape state machine and per-word decode into a result group
`default_nettype none
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_input_end,
    output t_res            o_res
);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_HEX0   = 3'd2,
        M_HEX1   = 3'd3,
        M_HEX2   = 3'd4,
        M_HEX3   = 3'd5
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [11:0] r_acc, n_acc;
    t_res        res;
    logic [4:0]  hd;
    logic [15:0] cp;

    assign hd = hex_digit(i_in_byte);
    assign cp = {r_acc, hd[3:0]};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        res    = '0;
        if (i_input_end) begin
            n_mode   = M_NORMAL;
            n_acc    = '0;
            res.cnt  = 2'd1;
            res.kind = KIND_UNTERM;
        end else begin
            unique case (r_mode)
                M_ESC: begin
                    n_mode   = M_NORMAL;
                    res.cnt  = 2'd1;
                    res.kind = KIND_DATA;
                    case (i_in_byte) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.b0 = i_in_byte;
                        CH_B: res.b0 = CTL_BS;
                        CH_F: res.b0 = CTL_FF;
                        CH_N: res.b0 = CTL_LF;
                        CH_R: res.b0 = CTL_CR;
                        CH_T: res.b0 = CTL_TAB;
                        CH_U: begin
                            n_mode  = M_HEX0;
                            n_acc   = '0;
                            res.cnt = 2'd0;
                        end
                        default: begin
                            n_acc    = '0;
                            res.kind = KIND_BAD_ESC;
                        end
                    endcase
                end
                M_HEX0, M_HEX1, M_HEX2: begin
                    if (!hd[4]) begin
                        n_mode   = M_NORMAL;
                        n_acc    = '0;
                        res.cnt  = 2'd1;
                        res.kind = KIND_BAD_HEX;
                    end else begin
                        n_mode = t_mode'(r_mode + 3'd1);
                        n_acc  = {r_acc[7:0], hd[3:0]};
                    end
                end
                M_HEX3: begin
                    n_mode   = M_NORMAL;
                    n_acc    = '0;
                    res.kind = KIND_DATA;
                    if (!hd[4]) begin
                        res.cnt  = 2'd1;
                        res.kind = KIND_BAD_HEX;
                    end else if (cp[15:7] == 9'd0) begin
                        res.cnt = 2'd1;
                        res.b0  = cp[7:0];
                    end else if (cp[15:11] == 5'd0) begin
                        res.cnt = 2'd2;
                        res.b0  = {3'b110, cp[10:6]};
                        res.b1  = {2'b10, cp[5:0]};
                    end else if (cp[15:11] == 5'b11011) begin
                        res.cnt  = 2'd1;
                        res.kind = KIND_SURR;
                    end else begin
                        res.cnt = 2'd3;
                        res.b0  = {4'b1110, cp[15:12]};
                        res.b1  = {2'b10, cp[11:6]};
                        res.b2  = {2'b10, cp[5:0]};
                    end
                end
                default: begin
                    res.cnt = 2'd1;
                    if (i_in_byte == CH_QUOTE) begin
                        n_mode   = M_NORMAL;
                        n_acc    = '0;
                        res.kind = KIND_END;
                    end else if (i_in_byte == CH_BSLASH) begin
                        n_mode  = M_ESC;
                        res.cnt = 2'd0;
                    end else begin
                        n_mode   = M_NORMAL;
                        res.kind = KIND_DATA;
                        res.b0   = i_in_byte;
                    end
                end
            endcase
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/jsu_outq.sv @@
// result register that sends a group of up to three bytes one word at a time
`default_nettype none
module jsu_outq
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_res       i_res,
    input  wire logic       i_out_ready,
    output logic            o_can_load,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_kind,
    output logic            o_last
);

    logic [1:0] r_cnt;
    logic [2:0] r_kind;
    logic [7:0] r_b0, r_b1, r_b2;
    logic       pop;

    assign pop         = (r_cnt != 2'd0) && i_out_ready;
    assign o_can_load  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out_byte  = r_b0;
    assign o_kind      = r_kind;
    assign o_last      = r_cnt == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load && i_res.cnt != 2'd0) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.cnt != 2'd0) begin
            r_kind <= i_res.kind;
            r_b0   <= i_res.b0;
            r_b1   <= i_res.b1;
            r_b2   <= i_res.b2;
        end else if (pop) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/json_string_unescape_utf8.sv @@
// top level of the json string body unescaper with utf-8 output
// Takes one raw byte of a JSON string body per word and gives the unescaped
// bytes, one per output word; a \uXXXX escape expands to one to three UTF-8
// bytes on its last hex digit, and string end or an error gives one word with
// a status kind and a zero byte. Each input word is decoded in the cycle it is
// accepted and its results land in a result register, so a word can be taken
// every cycle while each word yields at most one byte and the output is ready.
// The result register holds one group: after a word that yields two or three
// bytes, input is held off while the group drains. A stalled output holds off
// input until the last word of the pending group is taken.
`default_nettype none
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_input_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_kind,
    output logic            o_last
);

    t_res res;
    logic accept;

    assign accept = i_in_valid && o_in_ready;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_input_end (i_input_end),
        .o_res       (res)
    );

    jsu_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_can_load  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

`ifndef SYNTH
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_last && o_out_byte == 8'd0)
        else $error("status word not alone");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken while group pending");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= KIND_UNTERM)
        else $error("kind out of range");
`endif

endmodule
`default_nettype wire

@@ dv/json_string_unescape_utf8_test.sv @@
// testbench for the json string body unescaper: directed and random byte streams, checked per word
module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    localparam int QUIET_TAIL = 30;
    localparam int N_RANDOM = 236;

    typedef enum logic [2:0] {
        ST_NORMAL, ST_ESC, ST_HEX0, ST_HEX1, ST_HEX2, ST_HEX3
    } t_esc_state;

    typedef struct packed {
        logic [7:0] data;
        logic       stop;
    } t_raw_item;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } t_dec_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_input_end = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_kind;
    logic       o_last;

    t_raw_item  raw_q[$];
    t_dec_word  decoded_q[$];
    t_esc_state esc_state = ST_NORMAL;
    logic [11:0] hex_acc = 12'h000;
    int n_items = 0;
    int n_accepted = 0;
    int n_words = 0;
    int fail_count = 0;
    int send_gap = 0;
    int out_stall = 0;
    int kind_seen[6];

    json_string_unescape_utf8 i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_input_end (i_input_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic t_dec_word mk_word(input logic [7:0] d, input logic [2:0] k);
        return '{data: d, kind: k, last: 1'b0};
    endfunction

    // advances the decoder state by one input word and queues the words it yields
    function automatic void unescape_step(input logic [7:0] b, input logic stop);
        t_dec_word grp[$];
        logic [4:0] dig;
        logic [15:0] cp;
        dig = hex_val(b);
        cp = {hex_acc, dig[3:0]};
        if (stop) begin
            grp.push_back(mk_word(8'h00, KIND_UNTERM));
        end else begin
            case (esc_state)
                ST_NORMAL: begin
                    if (b == CH_QUOTE) grp.push_back(mk_word(8'h00, KIND_END));
                    else if (b == CH_BSLASH) esc_state = ST_ESC;
                    else grp.push_back(mk_word(b, KIND_DATA));
                end
                ST_ESC: begin
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: grp.push_back(mk_word(b, KIND_DATA));
                        CH_B: grp.push_back(mk_word(CTL_BS, KIND_DATA));
                        CH_F: grp.push_back(mk_word(CTL_FF, KIND_DATA));
                        CH_N: grp.push_back(mk_word(CTL_LF, KIND_DATA));
                        CH_R: grp.push_back(mk_word(CTL_CR, KIND_DATA));
                        CH_T: grp.push_back(mk_word(CTL_TAB, KIND_DATA));
                        CH_U: begin
                            esc_state = ST_HEX0;
                            hex_acc = 12'h000;
                        end
                        default: grp.push_back(mk_word(8'h00, KIND_BAD_ESC));
                    endcase
                end
                default: begin
                    if (!dig[4]) begin
                        grp.push_back(mk_word(8'h00, KIND_BAD_HEX));
                    end else if (esc_state != ST_HEX3) begin
                        hex_acc = {hex_acc[7:0], dig[3:0]};
                        esc_state = t_esc_state'(esc_state + 3'd1);
                    end else if (cp < 16'h0080) begin
                        grp.push_back(mk_word(cp[7:0], KIND_DATA));
                    end else if (cp < 16'h0800) begin
                        grp.push_back(mk_word({3'b110, cp[10:6]}, KIND_DATA));
                        grp.push_back(mk_word({2'b10, cp[5:0]}, KIND_DATA));
                    end else if (cp >= 16'hD800 && cp < 16'hE000) begin
                        grp.push_back(mk_word(8'h00, KIND_SURR));
                    end else begin
                        grp.push_back(mk_word({4'b1110, cp[15:12]}, KIND_DATA));
                        grp.push_back(mk_word({2'b10, cp[11:6]}, KIND_DATA));
                        grp.push_back(mk_word({2'b10, cp[5:0]}, KIND_DATA));
                    end
                end
            endcase
        end
        // every word-producing step leaves the decoder in normal mode
        if (grp.size() != 0) begin
            esc_state = ST_NORMAL;
            hex_acc = 12'h000;
            grp[grp.size() - 1].last = 1'b1;
        end
        foreach (grp[i]) decoded_q.push_back(grp[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'("0") + 8'(v);
        return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic stop);
        raw_q.push_back('{data: b, stop: stop});
    endtask

    task automatic push_unicode(input logic [15:0] cp);
        push_item(CH_BSLASH, 1'b0);
        push_item(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) push_item(hex_char(cp[i*4 +: 4]), 1'b0);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_raw_item nxt;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                unescape_step(i_in_byte, i_input_end);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (raw_q.size() != 0) begin
                    nxt = raw_q.pop_front();
                    i_in_byte <= nxt.data;
                    i_input_end <= nxt.stop;
                    i_in_valid <= 1'b1;
                    if (raw_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 18);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_dec_word want;
        if (o_out_valid && i_out_ready) begin
            n_words++;
            if (o_kind <= KIND_UNTERM) kind_seen[o_kind]++;
            if (decoded_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected word %0d: byte %h kind %0d last %b",
                             n_words, o_out_byte, o_kind, o_last);
                end
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data || o_kind !== want.kind
                        || o_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"mismatch at word %0d: expected byte %h kind %0d last %b,",
                                  " got byte %h kind %0d last %b"},
                                 n_words, want.data, want.kind, want.last,
                                 o_out_byte, o_kind, o_last);
                    end
                end
            end
        end
        if (out_stall != 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (raw_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                out_stall = $urandom_range(1, 18);
            end
        end
    end

    initial begin
        logic [7:0] b;
        logic [15:0] cp;
        logic ok;
        int len;

        // directed: byte extremes, string end, escapes, errors, code zero
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CH_QUOTE, 1'b0);
        push_item(CH_BSLASH, 1'b0);
        push_item(CH_N, 1'b0);
        push_item(CH_BSLASH, 1'b0);
        push_item("q", 1'b0);
        push_item(CH_BSLASH, 1'b0);
        push_item(CH_U, 1'b0);
        push_item(CH_QUOTE, 1'b0);
        push_unicode(16'h0000);
        push_unicode(16'hD800);
        push_item(CH_BSLASH, 1'b0);
        push_item(8'h5A, 1'b1);

        while (raw_q.size() < 24 + N_RANDOM) begin
            len = $urandom_range(0, 99);
            if (len < 35) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                push_item(b, 1'b0);
            end else if (len < 45) begin
                push_item(CH_QUOTE, 1'b0);
            end else if (len < 60) begin
                push_item(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0: push_item(CH_QUOTE, 1'b0);
                    1: push_item(CH_BSLASH, 1'b0);
                    2: push_item(CH_SLASH, 1'b0);
                    3: push_item(CH_B, 1'b0);
                    4: push_item(CH_F, 1'b0);
                    5: push_item(CH_N, 1'b0);
                    6: push_item(CH_R, 1'b0);
                    default: push_item(CH_T, 1'b0);
                endcase
            end else if (len < 82) begin
                case ($urandom_range(0, 6))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: cp = 16'($urandom_range(16'h0800, 16'hD7FF));
                    3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                    4: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
                    5: cp = 16'($urandom);
                    default: begin
                        case ($urandom_range(0, 8))
                            0: cp = 16'h007F;
                            1: cp = 16'h0080;
                            2: cp = 16'h07FF;
                            3: cp = 16'h0800;
                            4: cp = 16'hD7FF;
                            5: cp = 16'hDFFF;
                            6: cp = 16'hE000;
                            7: cp = 16'hFFFF;
                            default: cp = 16'h0000;
                        endcase
                    end
                endcase
                push_unicode(cp);
            end else if (len < 88) begin
                do begin
                    b = 8'($urandom_range(0, 255));
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U:
                            ok = 1'b0;
                        default: ok = 1'b1;
                    endcase
                end while (!ok);
                push_item(CH_BSLASH, 1'b0);
                push_item(b, 1'b0);
            end else if (len < 94) begin
                push_item(CH_BSLASH, 1'b0);
                push_item(CH_U, 1'b0);
                repeat ($urandom_range(0, 3)) push_item(hex_char(4'($urandom)), 1'b0);
                if ($urandom_range(0, 3) == 0) b = CH_QUOTE;
                else do b = 8'($urandom_range(0, 255)); while (hex_val(b) != 5'd0);
                push_item(b, 1'b0);
            end else begin
                // input ends, possibly in the middle of an escape
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    if (k == 0) push_item(CH_BSLASH, 1'b0);
                    else if (k == 1) push_item(CH_U, 1'b0);
                    else push_item(hex_char(4'($urandom)), 1'b0);
                end
                push_item(8'($urandom), 1'b1);
            end
        end
        n_items = raw_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d input bytes, %0d output words, %0d mismatches",
                 n_accepted, n_words, fail_count);
        $display({"kinds: data %0d, end %0d, bad escape %0d, bad hex %0d,",
                  " surrogate %0d, unterminated %0d"},
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout: %0d of %0d bytes taken, %0d words outstanding",
                 n_accepted, n_items, decoded_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_outq.sv
rtl/core/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_test.sv
